// ----- hdl/rmq_pkg.sv -----
// Package for the rotation matrix to quaternion converter: widths and path codes.
package rmq_pkg;

    localparam int VALUE_WIDTH_DEF   = 16;
    localparam int FRACTION_BITS_DEF = 14;

    typedef enum logic [1:0] {
        PATH_TRACE = 2'd0,
        PATH_X     = 2'd1,
        PATH_Y     = 2'd2,
        PATH_Z     = 2'd3
    } path_t;

endpackage

// ----- hdl/rotation_matrix_to_quaternion_core.sv -----
// Top level of the rotation matrix to quaternion converter, fully pipelined.
// Converts a 3x3 rotation matrix (signed Q1.FRACTION_BITS) to a quaternion
// with Shoemake's method. One matrix is accepted every cycle while the pipe is
// not stalled. One stage chooses the path, a restoring square root
// takes one result bit per stage (RB stages), one stage loads the divider,
// a shared-divisor restoring divider yields one quotient bit per stage for
// three lanes (QB stages), and a final stage rounds, saturates and places the
// components. A stall freezes the whole pipe. A non-positive root argument
// raises invalid and gives zero components, while major_path still reports
// the chosen path.
module rotation_matrix_to_quaternion_core #(
    parameter int VALUE_WIDTH   = rmq_pkg::VALUE_WIDTH_DEF,
    parameter int FRACTION_BITS = rmq_pkg::FRACTION_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [VALUE_WIDTH-1:0] m00,
    input  logic signed [VALUE_WIDTH-1:0] m01,
    input  logic signed [VALUE_WIDTH-1:0] m02,
    input  logic signed [VALUE_WIDTH-1:0] m10,
    input  logic signed [VALUE_WIDTH-1:0] m11,
    input  logic signed [VALUE_WIDTH-1:0] m12,
    input  logic signed [VALUE_WIDTH-1:0] m20,
    input  logic signed [VALUE_WIDTH-1:0] m21,
    input  logic signed [VALUE_WIDTH-1:0] m22,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [VALUE_WIDTH-1:0] qw,
    output logic signed [VALUE_WIDTH-1:0] qx,
    output logic signed [VALUE_WIDTH-1:0] qy,
    output logic signed [VALUE_WIDTH-1:0] qz,
    output logic [1:0]                    major_path,
    output logic                          invalid
);

    // argument width: |arg| <= 3*2^(W-1)+2^F, fits W+2 bits signed
    localparam int AW  = VALUE_WIDTH + 2;
    // radicand = arg << (F-2), positive part below 2^(AW-1+F-2)
    localparam int RW0 = AW - 1 + FRACTION_BITS - 2;
    localparam int RW  = RW0 + (RW0 % 2);
    localparam int RB  = RW / 2;
    // difference width and dividend magnitude width
    localparam int DW  = VALUE_WIDTH + 1;
    localparam int NW  = DW + FRACTION_BITS;
    // quotient bits computed; anything above saturates anyway
    localparam int QB  = NW;
    localparam int DVW = RB + 2;
    localparam int RMW = DVW + 1;
    localparam int NS  = RB + QB + 2;

    typedef struct packed {
        logic [1:0]          path;
        logic                bad;
        logic [2:0]          neg;
        logic [3*NW-1:0]     num;
    } info_t;

    logic advance;
    assign advance  = !out_stall || !out_valid;
    assign in_stall = !advance;

    // stage 0: path choice, root argument, differences
    logic signed [AW-1:0] e00, e11, e22, tr, arg;
    logic signed [DW-1:0] d0, d1, d2;
    logic [1:0] path;
    always_comb
    begin
        e00 = AW'(m00);
        e11 = AW'(m11);
        e22 = AW'(m22);
        tr  = e00 + e11 + e22;
        d0  = '0;
        d1  = '0;
        d2  = '0;
        if (tr > 0)
        begin
            path = rmq_pkg::PATH_TRACE;
            arg  = tr + AW'(1 << FRACTION_BITS);
            d0 = DW'(m21) - DW'(m12);
            d1 = DW'(m02) - DW'(m20);
            d2 = DW'(m10) - DW'(m01);
        end
        else if (m22 > m11 && m22 > m00)
        begin
            path = rmq_pkg::PATH_Z;
            arg  = e22 - e00 - e11 + AW'(1 << FRACTION_BITS);
            // i=2 j=0 k=1: w, x, y
            d0 = DW'(m10) - DW'(m01);
            d1 = DW'(m02) + DW'(m20);
            d2 = DW'(m12) + DW'(m21);
        end
        else if (m11 > m00)
        begin
            path = rmq_pkg::PATH_Y;
            arg  = e11 - e22 - e00 + AW'(1 << FRACTION_BITS);
            // i=1 j=2 k=0: w, z, x
            d0 = DW'(m02) - DW'(m20);
            d1 = DW'(m21) + DW'(m12);
            d2 = DW'(m01) + DW'(m10);
        end
        else
        begin
            path = rmq_pkg::PATH_X;
            arg  = e00 - e11 - e22 + AW'(1 << FRACTION_BITS);
            // i=0 j=1 k=2: w, y, z
            d0 = DW'(m21) - DW'(m12);
            d1 = DW'(m10) + DW'(m01);
            d2 = DW'(m20) + DW'(m02);
        end
    end

    // pipeline registers
    logic              vld_reg [NS+1];
    info_t             inf_reg [NS];
    logic [RW-1:0]     rad_reg [RB+1];
    logic [RB+1:0]     rem_reg [RB+1];
    logic [RB-1:0]     rt_reg  [RB+1];
    logic [DVW-1:0]    dv_reg  [QB+1];
    logic [RMW-1:0]    qr_reg  [3][QB+1];
    logic [NW-1:0]     qn_reg  [3][QB+1];
    logic [QB-1:0]     qq_reg  [3][QB+1];

    logic [DW-1:0] dm0, dm1, dm2;
    assign dm0 = d0[DW-1] ? DW'(-d0) : DW'(d0);
    assign dm1 = d1[DW-1] ? DW'(-d1) : DW'(d1);
    assign dm2 = d2[DW-1] ? DW'(-d2) : DW'(d2);

    // advance valid bits, one per stage including the output stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= NS; s++)
                vld_reg[s] <= 1'b0;
        end
        else if (advance)
        begin
            vld_reg[0] <= in_valid;
            for (int s = 1; s <= NS; s++)
                vld_reg[s] <= vld_reg[s-1];
        end
    end

    // entry stage
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            inf_reg[0].path <= path;
            inf_reg[0].bad  <= (arg <= 0);
            inf_reg[0].neg  <= {d2[DW-1], d1[DW-1], d0[DW-1]};
            inf_reg[0].num  <= {dm2, {FRACTION_BITS{1'b0}}, dm1, {FRACTION_BITS{1'b0}},
                                dm0, {FRACTION_BITS{1'b0}}};
            rad_reg[0] <= (arg <= 0) ? '0 :
                RW'({arg[AW-2:0], {(FRACTION_BITS-2){1'b0}}});
            rem_reg[0] <= '0;
            rt_reg[0]  <= '0;
        end
    end

    // square root stages: one root bit each
    for (genvar s = 0; s < RB; s++)
    begin : g_sqrt
        logic [RB+1:0] trial, rem_n;
        always_comb
        begin
            rem_n = {rem_reg[s][RB-1:0], rad_reg[s][RW-1 -: 2]};
            trial = rem_n - {rt_reg[s], 2'b01};
        end
        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                inf_reg[s+1] <= inf_reg[s];
                rad_reg[s+1] <= {rad_reg[s][RW-3:0], 2'b00};
                if (!trial[RB+1])
                begin
                    rem_reg[s+1] <= trial;
                    rt_reg[s+1]  <= {rt_reg[s][RB-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[s+1] <= rem_n;
                    rt_reg[s+1]  <= {rt_reg[s][RB-2:0], 1'b0};
                end
            end
        end
    end

    // divider entry: divisor 4h, dividends num
    logic [RB-1:0] h_root;
    assign h_root = rt_reg[RB];
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            inf_reg[RB+1] <= inf_reg[RB];
            dv_reg[0] <= {h_root, 2'b00};
        end
    end

    // load each divider lane
    for (genvar l = 0; l < 3; l++)
    begin : g_lane_in
        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                qr_reg[l][0] <= '0;
                qn_reg[l][0] <= inf_reg[RB].num[l*NW +: NW];
                qq_reg[l][0] <= '0;
            end
        end
    end

    // divider stages: one quotient bit per lane each
    for (genvar s = 0; s < QB; s++)
    begin : g_div
        for (genvar l = 0; l < 3; l++)
        begin : g_lane
            logic [RMW:0] sh, df;
            always_comb
            begin
                sh = {qr_reg[l][s], qn_reg[l][s][NW-1]};
                df = sh - (RMW+1)'(dv_reg[s]);
            end
            always_ff @(posedge clk)
            begin
                if (advance)
                begin
                    qn_reg[l][s+1] <= {qn_reg[l][s][NW-2:0], 1'b0};
                    if (!df[RMW])
                    begin
                        qr_reg[l][s+1] <= df[RMW-1:0];
                        qq_reg[l][s+1] <= {qq_reg[l][s][QB-2:0], 1'b1};
                    end
                    else
                    begin
                        qr_reg[l][s+1] <= sh[RMW-1:0];
                        qq_reg[l][s+1] <= {qq_reg[l][s][QB-2:0], 1'b0};
                    end
                end
            end
        end
        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                inf_reg[RB+2+s] <= inf_reg[RB+1+s];
                dv_reg[s+1]     <= dv_reg[s];
            end
        end
    end

    // hold h alongside the divider
    logic [RB-1:0] hh_reg [QB+1];
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            hh_reg[0] <= h_root;
            for (int s = 1; s <= QB; s++)
                hh_reg[s] <= hh_reg[s-1];
        end
    end

    // round half away (2r >= d), saturate, place
    localparam logic signed [QB+2:0] VMAXL = (QB+3)'((1 << (VALUE_WIDTH-1)) - 1);
    logic signed [VALUE_WIDTH-1:0] cs [3];
    logic signed [VALUE_WIDTH-1:0] hs;
    info_t fin;
    assign fin = inf_reg[NS-1];
    for (genvar l = 0; l < 3; l++)
    begin : g_rnd
        logic [QB:0] qr;
        logic signed [QB+2:0] qs;
        always_comb
        begin
            qr = {1'b0, qq_reg[l][QB]} +
                 (QB+1)'(({qr_reg[l][QB], 1'b0} >= {1'b0, dv_reg[QB]}) ? 1 : 0);
            qs = fin.neg[l] ? -(QB+3)'(qr) : (QB+3)'(qr);
            if (qs > VMAXL)
                cs[l] = VALUE_WIDTH'(VMAXL);
            else if (qs < -VMAXL - 1)
                cs[l] = VALUE_WIDTH'(-VMAXL - 1);
            else
                cs[l] = VALUE_WIDTH'(qs);
        end
    end
    always_comb
    begin
        if ((RB+1)'(hh_reg[QB]) > (RB+1)'(VMAXL))
            hs = VALUE_WIDTH'(VMAXL);
        else
            hs = VALUE_WIDTH'(hh_reg[QB]);
    end

    logic signed [VALUE_WIDTH-1:0] qw_reg, qx_reg, qy_reg, qz_reg;
    logic [1:0] path_reg;
    logic       bad_reg;
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            path_reg <= fin.path;
            bad_reg  <= fin.bad;
            if (fin.bad)
            begin
                qw_reg <= '0; qx_reg <= '0; qy_reg <= '0; qz_reg <= '0;
            end
            else
            begin
                unique case (fin.path)
                    rmq_pkg::PATH_TRACE:
                    begin
                        qw_reg <= hs; qx_reg <= cs[0]; qy_reg <= cs[1]; qz_reg <= cs[2];
                    end
                    rmq_pkg::PATH_X:
                    begin
                        qw_reg <= cs[0]; qx_reg <= hs; qy_reg <= cs[1]; qz_reg <= cs[2];
                    end
                    rmq_pkg::PATH_Y:
                    begin
                        qw_reg <= cs[0]; qy_reg <= hs; qz_reg <= cs[1]; qx_reg <= cs[2];
                    end
                    default:
                    begin
                        qw_reg <= cs[0]; qz_reg <= hs; qx_reg <= cs[1]; qy_reg <= cs[2];
                    end
                endcase
            end
        end
    end

    assign out_valid  = vld_reg[NS];
    assign qw         = qw_reg;
    assign qx         = qx_reg;
    assign qy         = qy_reg;
    assign qz         = qz_reg;
    assign major_path = path_reg;
    assign invalid    = bad_reg;

endmodule
